// File: src/pat_pkg.sv
// Shared codes and controller/datapath interface types for the positional array table.
package pat_pkg;

  typedef logic [1:0] req_t;
  typedef logic [1:0] status_t;

  localparam req_t REQ_INSERT = 2'd0;
  localparam req_t REQ_SEARCH = 2'd1;
  localparam req_t REQ_DELETE = 2'd2;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NOTFOUND = 2'd1;
  localparam status_t ST_BADPOS   = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_COUNT,
    PTR_POS,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC
  } ptr_op_t;

  typedef struct packed {
    logic    latch;
    ptr_op_t ptr_op;
    logic    wr_shift;
    logic    wr_value;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_set;
    status_t res_status;
    logic    res_found;
    logic    out_load;
  } pat_cmd_t;

  typedef struct packed {
    req_t req;
    logic full;
    logic ins_bad;
    logic del_bad;
    logic append;
    logic del_last;
    logic cnt_zero;
    logic at_pos;
    logic del_more;
    logic match;
    logic srch_last;
    logic out_free;
  } pat_stat_t;

endpackage

// File: src/positional_array_table.sv
// Top level of the positional array table: controller and datapath joined by command and status.
//
//  channel | direction | tdata (low bit up)                  | tuser
//  s_*     | in        | position[4:0], value[36:5], pad     | req_type[1:0]
//  m_*     | out       | found_index[3:0], entry_count[8:4]  | status[1:0]
//
// One request at a time; entries move through one memory read port and one write port,
// each entry moved or compared in a read state and then a write or compare state; a
// rejected request goes from the decide state straight to the response. Synchronous
// active-high reset clears count and the output valid; entry contents are left as
// they are. While a result waits, one more request can run up to its response state
// and hold there; a new request is taken the cycle after the result is registered.
module positional_array_table #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // position[4:0], value[36:5], zero pad [39:37]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // found_index[3:0], entry_count[8:4], zero pad [15:9]
  output logic [1:0]  m_tuser    // status[1:0]
);
  import pat_pkg::*;

  pat_cmd_t   cmd;
  pat_stat_t  stat;
  logic [3:0] out_idx;
  logic [4:0] out_count;

  pat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pat_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_req     (s_tuser),
    .in_pos     (s_tdata[4:0]),
    .in_val     (s_tdata[36:5]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_idx    (out_idx),
    .out_count  (out_count)
  );

  assign m_tdata = {7'd0, out_count, out_idx};

endmodule

// File: src/pat_datapath.sv
// Datapath: request registers, entry memory, count, pointer, result and output registers.
module pat_datapath #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  pat_pkg::pat_cmd_t cmd,
  output pat_pkg::pat_stat_t stat,
  input  logic [1:0]        in_req,
  input  logic [4:0]        in_pos,
  input  logic [31:0]       in_val,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [3:0]        out_idx,
  output logic [4:0]        out_count
);
  import pat_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int AW   = $clog2(DEPTH);
  localparam int CMPW = ((CW > 5) ? CW : 5) + 1;

  req_t              req_q;
  logic [4:0]        pos_q;
  logic [31:0]       val_q;
  logic [CW-1:0]     cnt;
  logic [AW-1:0]     ptr;
  logic [31:0]       mem [DEPTH];
  logic [31:0]       rdata;
  logic [AW-1:0]     rd_addr;
  status_t           res_status;
  logic [3:0]        res_idx;

  logic [CMPW-1:0]   cnt_x;
  logic [CMPW-1:0]   pos_x;
  logic [CMPW-1:0]   ptr_x;
  logic [CMPW-1:0]   pos_m1;

  assign cnt_x  = CMPW'(cnt);
  assign pos_x  = CMPW'(pos_q);
  assign ptr_x  = CMPW'(ptr);
  assign pos_m1 = pos_x - CMPW'(1);

  // Insert moves entry ptr-1 up into ptr; delete moves ptr+1 down into ptr.
  always_comb begin
    case (req_q)
      REQ_INSERT: rd_addr = AW'(ptr - AW'(1));
      REQ_DELETE: rd_addr = AW'(ptr + AW'(1));
      default:    rd_addr = ptr;
    endcase
  end

  always_comb begin
    stat.req       = req_q;
    stat.full      = (cnt_x >= CMPW'(DEPTH));
    stat.ins_bad   = (pos_q == 5'd0) || (pos_x > cnt_x + CMPW'(1));
    stat.del_bad   = (pos_q == 5'd0) || (pos_x > cnt_x);
    stat.append    = (pos_x == cnt_x + CMPW'(1));
    stat.del_last  = (pos_x == cnt_x);
    stat.cnt_zero  = (cnt_x == '0);
    stat.at_pos    = (ptr_x == pos_x);
    stat.del_more  = (ptr_x + CMPW'(2) < cnt_x);
    stat.match     = (rdata == val_q);
    stat.srch_last = (ptr_x + CMPW'(1) == cnt_x);
    stat.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
    if (cmd.wr_shift) begin
      mem[ptr] <= rdata;
    end else if (cmd.wr_value) begin
      mem[AW'(pos_m1)] <= val_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_q <= in_req;
      pos_q <= in_pos;
      val_q <= in_val;
    end
    case (cmd.ptr_op)
      PTR_COUNT: ptr <= AW'(cnt);
      PTR_POS:   ptr <= AW'(pos_m1);
      PTR_ZERO:  ptr <= '0;
      PTR_INC:   ptr <= AW'(ptr + AW'(1));
      PTR_DEC:   ptr <= AW'(ptr - AW'(1));
      default:   ptr <= ptr;
    endcase
    if (cmd.res_set) begin
      res_status <= cmd.res_status;
      res_idx    <= cmd.res_found ? ptr_x[3:0] : 4'd0;
    end
    if (cmd.out_load) begin
      out_status <= res_status;
      out_idx    <= res_idx;
      out_count  <= cnt_x[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        cnt <= CW'(cnt + CW'(1));
      end else if (cmd.cnt_dec) begin
        cnt <= CW'(cnt - CW'(1));
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: src/pat_ctrl.sv
// Controller: sequences one request through checks, entry moves, search and response.
module pat_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pat_pkg::pat_stat_t stat,
  output pat_pkg::pat_cmd_t  cmd
);
  import pat_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_WR,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_RESP
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.ptr_op = PTR_HOLD;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (stat.req)
          REQ_INSERT: begin
            if (stat.full) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_FULL;
              state_next     = S_RESP;
            end else if (stat.ins_bad) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_BADPOS;
              state_next     = S_RESP;
            end else if (stat.append) begin
              state_next = S_INS_WR;
            end else begin
              cmd.ptr_op = PTR_COUNT;
              state_next = S_SHIFT_RD;
            end
          end
          REQ_DELETE: begin
            if (stat.del_bad) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_BADPOS;
              state_next     = S_RESP;
            end else if (stat.del_last) begin
              cmd.cnt_dec    = 1'b1;
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_OK;
              state_next     = S_RESP;
            end else begin
              cmd.ptr_op = PTR_POS;
              state_next = S_SHIFT_RD;
            end
          end
          REQ_SEARCH: begin
            if (stat.cnt_zero) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_NOTFOUND;
              state_next     = S_RESP;
            end else begin
              cmd.ptr_op = PTR_ZERO;
              state_next = S_SRCH_RD;
            end
          end
          default: begin
            cmd.res_set    = 1'b1;
            cmd.res_status = ST_BADPOS;
            state_next     = S_RESP;
          end
        endcase
      end
      S_SHIFT_RD: begin
        state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        if (stat.req == REQ_INSERT) begin
          // the slot at pos-1 is now free for the new value
          if (stat.at_pos) begin
            state_next = S_INS_WR;
          end else begin
            cmd.ptr_op = PTR_DEC;
            state_next = S_SHIFT_RD;
          end
        end else begin
          if (stat.del_more) begin
            cmd.ptr_op = PTR_INC;
            state_next = S_SHIFT_RD;
          end else begin
            cmd.cnt_dec    = 1'b1;
            cmd.res_set    = 1'b1;
            cmd.res_status = ST_OK;
            state_next     = S_RESP;
          end
        end
      end
      S_INS_WR: begin
        cmd.wr_value   = 1'b1;
        cmd.cnt_inc    = 1'b1;
        cmd.res_set    = 1'b1;
        cmd.res_status = ST_OK;
        state_next     = S_RESP;
      end
      S_SRCH_RD: begin
        state_next = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (stat.match) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_OK;
          cmd.res_found  = 1'b1;
          state_next     = S_RESP;
        end else if (stat.srch_last) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_NOTFOUND;
          state_next     = S_RESP;
        end else begin
          cmd.ptr_op = PTR_INC;
          state_next = S_SRCH_RD;
        end
      end
      S_RESP: begin
        // hold until the output register can take the result
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: src/pat_checker.sv
// Port-level checks for the positional array table, bound to the top level.
module pat_checker #(
  parameter int DEPTH = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [39:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import pat_pkg::*;

  localparam logic [4:0] DEPTH_LO = 5'(DEPTH);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // one request in flight: no back-to-back acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while one is in flight");

  a_idx_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_OK) |-> m_tdata[3:0] == 4'd0)
    else $error("found_index nonzero on a failed request");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_FULL) |-> m_tdata[8:4] == DEPTH_LO)
    else $error("table full reported with count below depth");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (DEPTH > 31) || (int'(m_tdata[8:4]) <= DEPTH))
    else $error("entry_count above depth");

endmodule

bind positional_array_table pat_checker #(.DEPTH(DEPTH)) u_pat_checker (.*);

// File: dv/positional_array_table_tb.sv
// Self-checking stream testbench for the positional array table: insert, search, delete.
module positional_array_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pat_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int LONG_HOLD   = 300;
  localparam int TAIL_CYCLES = 2 * TABLE_DEPTH + 8;
  localparam req_t REQ_UNUSED = 2'd3;

  typedef struct packed {
    status_t    status;
    logic [3:0] found_index;
    logic [4:0] entry_count;
  } table_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // position[4:0], value[36:5], zero pad [39:37]
  logic [1:0]  s_tuser = '0;   // req_type[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // found_index[3:0], entry_count[8:4], zero pad [15:9]
  logic [1:0]  m_tuser;        // status[1:0]

  // Shadow of the table contents and fill level
  logic signed [31:0] tbl_vals [TABLE_DEPTH];
  int                 tbl_count = 0;

  table_result_t pending_results[$];

  int  n_mismatch = 0;
  int  results_seen = 0;
  int  req_sent [4] = '{0, 0, 0, 0};
  int  status_seen [4] = '{0, 0, 0, 0};
  bit  tx_idle = 1'b1;
  bit  rx_idle = 1'b1;
  int  hold_asks = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  int  rx_wait = 0;

  positional_array_table #(.DEPTH(TABLE_DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(5_000_000);
    $display("end of test: mismatches");
    $finish;
  end

  // Apply one request to the shadow table and return the result it should give
  function automatic table_result_t apply_table_op(req_t req, logic [4:0] pos,
                                                   logic [31:0] val);
    table_result_t r;
    int p;
    int k;
    bit hit;
    r.status = ST_OK;
    r.found_index = '0;
    p = int'(pos);
    hit = 1'b0;
    case (req)
      REQ_INSERT: begin
        if (tbl_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else if (p == 0 || p > tbl_count + 1) begin
          r.status = ST_BADPOS;
        end else begin
          for (k = tbl_count; k >= p; k--) tbl_vals[k] = tbl_vals[k - 1];
          tbl_vals[p - 1] = val;
          tbl_count++;
        end
      end
      REQ_SEARCH: begin
        for (k = 0; k < tbl_count && !hit; k++) begin
          if (tbl_vals[k] == val) begin
            hit = 1'b1;
            r.found_index = k[3:0];
          end
        end
        if (!hit) r.status = ST_NOTFOUND;
      end
      REQ_DELETE: begin
        if (p == 0 || p > tbl_count) begin
          r.status = ST_BADPOS;
        end else begin
          for (k = p - 1; k + 1 < tbl_count; k++) tbl_vals[k] = tbl_vals[k + 1];
          tbl_count--;
        end
      end
      default: r.status = ST_BADPOS;
    endcase
    r.entry_count = tbl_count[4:0];
    return r;
  endfunction

  // Offer one request, hold it until accepted, then log its expected result
  task automatic send_request(req_t req, logic [4:0] pos, logic [31:0] val);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, val, pos};
    s_tuser  <= req;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(apply_table_op(req, pos, val));
    req_sent[req]++;
  endtask

  task automatic drain_requests();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(signed'($urandom_range(0, 6)) - 3);
      3: return 32'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  // Mostly legal requests against the current fill level, some noise
  task automatic send_random_item(bit grow);
    req_t       req;
    logic [4:0] pos;
    logic [31:0] val;
    int roll;
    pos = 5'($urandom_range(0, 31));
    val = pick_value();
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      req = req_t'($urandom_range(0, 3));
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        req = REQ_SEARCH;
        if (tbl_count > 0 && $urandom_range(0, 2) != 0)
          val = tbl_vals[$urandom_range(0, tbl_count - 1)];
      end else if (roll < (grow ? 85 : 45)) begin
        req = REQ_INSERT;
        pos = 5'($urandom_range(1, tbl_count + 1));
      end else begin
        req = REQ_DELETE;
        pos = 5'($urandom_range(1, (tbl_count > 0) ? tbl_count : 1));
      end
    end
    send_request(req, pos, val);
  endtask

  task automatic test_directed_cases();
    send_request(REQ_SEARCH, 5'd0, 32'd0);
    send_request(REQ_DELETE, 5'd1, 32'd0);
    send_request(REQ_DELETE, 5'd0, 32'd0);
    send_request(REQ_INSERT, 5'd0, 32'd9);
    send_request(REQ_INSERT, 5'd2, 32'd9);
    send_request(REQ_INSERT, 5'd1, 32'h8000_0000);
    send_request(REQ_INSERT, 5'd2, 32'h7fff_ffff);
    send_request(REQ_INSERT, 5'd1, 32'hffff_ffff);
    send_request(REQ_INSERT, 5'd2, 32'd5);
    send_request(REQ_INSERT, 5'd5, 32'd5);
    // duplicate value: first match wins
    send_request(REQ_SEARCH, 5'd31, 32'd5);
    send_request(REQ_SEARCH, 5'd0, 32'h7fff_ffff);
    send_request(REQ_SEARCH, 5'd0, 32'h8000_0000);
    send_request(REQ_SEARCH, 5'd0, 32'd12345);
    send_request(REQ_UNUSED, 5'd1, 32'd5);
    send_request(REQ_INSERT, 5'd7, 32'd1);
    send_request(REQ_DELETE, 5'd6, 32'd0);
    send_request(REQ_DELETE, 5'd5, 32'd0);
    send_request(REQ_DELETE, 5'd1, 32'd0);
    send_request(REQ_INSERT, 5'd31, 32'h5555_5555);
    send_request(REQ_DELETE, 5'd16, 32'd0);
    send_request(REQ_SEARCH, 5'd0, 32'haaaa_aaaa);
    send_request(REQ_DELETE, 5'd2, 32'd0);
  endtask

  task automatic test_full_table();
    while (tbl_count < TABLE_DEPTH)
      send_request(REQ_INSERT, 5'($urandom_range(1, tbl_count + 1)), pick_value());
    // full check comes ahead of the position check
    send_request(REQ_INSERT, 5'd0, 32'd1);
    send_request(REQ_INSERT, 5'd17, 32'd1);
    send_request(REQ_INSERT, 5'd8, 32'd1);
    send_request(REQ_SEARCH, 5'd0, tbl_vals[TABLE_DEPTH - 1]);
    send_request(REQ_DELETE, 5'd17, 32'd0);
    send_request(REQ_DELETE, 5'd16, 32'd0);
    send_request(REQ_INSERT, 5'd16, 32'hdead_beef);
    while (tbl_count > 0)
      send_request(REQ_DELETE, 5'($urandom_range(1, tbl_count)), $urandom);
    send_request(REQ_DELETE, 5'd1, 32'd0);
  endtask

  task automatic test_back_to_back(int n_items);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    for (int i = 0; i < n_items; i++) send_random_item(i % 40 < 20);
  endtask

  task automatic test_output_stall(int n_items);
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    hold_asks++;
    for (int i = 0; i < n_items; i++) send_random_item(1'b1);
  endtask

  task automatic test_random_mix(int n_items);
    for (int i = 0; i < n_items; i++) begin
      if (i % 150 == 0) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      // swing between filling and emptying so both ends get hit
      send_random_item((i / 100) % 2 == 0);
    end
  endtask

  // Result side: per-transaction random wait, plus a long hold on request
  always @(posedge clk) begin : rx_ready_ctl
    int w;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait  <= 0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= LONG_HOLD;
      m_tready  <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      w = rx_idle ? $urandom_range(0, 9) : 0;
      rx_wait  <= w;
      m_tready <= (w == 0);
    end else if (rx_wait > 0) begin
      rx_wait  <= rx_wait - 1;
      m_tready <= (rx_wait == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic void flag_field(string field, int exp_v, int got_v);
    n_mismatch++;
    if (n_mismatch <= 10)
      $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, field, exp_v, got_v);
  endfunction

  always @(posedge clk) begin : result_check
    table_result_t exp_r;
    status_t       got_st;
    logic [3:0]    got_idx;
    logic [4:0]    got_cnt;
    if (!rst && m_tvalid && m_tready) begin
      got_st  = m_tuser;
      got_idx = m_tdata[3:0];
      got_cnt = m_tdata[8:4];
      results_seen++;
      status_seen[got_st]++;
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("[%0t] unexpected result: status %0d index %0d count %0d",
                   $realtime, got_st, got_idx, got_cnt);
      end else begin
        exp_r = pending_results.pop_front();
        if (got_st !== exp_r.status) flag_field("status", exp_r.status, got_st);
        if (got_idx !== exp_r.found_index)
          flag_field("found_index", exp_r.found_index, got_idx);
        if (got_cnt !== exp_r.entry_count)
          flag_field("entry_count", exp_r.entry_count, got_cnt);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_full_table();
    test_back_to_back(100);
    test_output_stall(40);
    test_random_mix(1000);

    drain_requests();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      n_mismatch += pending_results.size();
    end
    $display("requests: %0d insert, %0d search, %0d delete, %0d unused selector",
             req_sent[REQ_INSERT], req_sent[REQ_SEARCH], req_sent[REQ_DELETE],
             req_sent[REQ_UNUSED]);
    $display("results: %0d checked; ok %0d, not found %0d, bad position %0d, full %0d",
             results_seen, status_seen[ST_OK], status_seen[ST_NOTFOUND],
             status_seen[ST_BADPOS], status_seen[ST_FULL]);
    if (n_mismatch == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
src/pat_pkg.sv
src/pat_datapath.sv
src/pat_ctrl.sv
src/positional_array_table.sv
src/pat_checker.sv
dv/positional_array_table_tb.sv
